@@ sv/ips_patch_stream_parser_assert.svh @@
// assertion macros for the ips patch stream parser
`ifndef IPS_PATCH_STREAM_PARSER_ASSERT_SVH
`define IPS_PATCH_STREAM_PARSER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IPSP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define IPSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ipsp_pkg.sv @@
// types, constants and helpers shared by the ips patch parser files
`default_nettype none

package ipsp_pkg;

    localparam int ADDR_W = 25;
    localparam int OFF_W  = 24;
    localparam int CNT_W  = 16;
    localparam int BYTE_W = 8;
    localparam int SEEN_W = 4;
    localparam int IDX_W  = 3;

    localparam logic [OFF_W-1:0]  EOF_TAG   = 24'h454F46;
    localparam logic [SEEN_W-1:0] MIN_PATCH = 4'd8;
    localparam logic [IDX_W-1:0]  HDR_LEN   = 3'd5;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_OFFSET = 6'b000010,
        PH_LENGTH = 6'b000100,
        PH_RUN    = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_DONE   = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FILL  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_OK      = 2'd1,
        ST_BAD     = 2'd2
    } t_status;

    typedef struct packed {
        logic              last_byte;
        logic [BYTE_W-1:0] patch_byte;
    } t_beat;

    typedef struct packed {
        t_action           action;
        logic [ADDR_W-1:0] target_address;
        logic [CNT_W-1:0]  fill_count;
        logic [BYTE_W-1:0] byte_value;
        logic [ADDR_W-1:0] image_length;
        t_status           status;
    } t_result;

    typedef struct packed {
        t_phase            phase;
        t_status           outcome;
        logic [SEEN_W-1:0] bytes_seen;
    } t_core_stat;

    // "PATCH"
    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [IDX_W-1:0] idx);
        logic [BYTE_W-1:0] r;
        unique case (idx)
            3'd0:    r = 8'h50;
            3'd1:    r = 8'h41;
            3'd2:    r = 8'h54;
            3'd3:    r = 8'h43;
            3'd4:    r = 8'h48;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/ipsp_stream_if.sv @@
// handshake interfaces for patch bytes in and commands out
`default_nettype none

interface ipsp_byte_if import ipsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] patch_byte;
    logic              last_byte;

    modport source (output valid, patch_byte, last_byte, input ready);
    modport sink   (input valid, patch_byte, last_byte, output ready);
endinterface

interface ipsp_cmd_if import ipsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [ADDR_W-1:0] target_address;
    logic [CNT_W-1:0]  fill_count;
    logic [BYTE_W-1:0] byte_value;
    logic [ADDR_W-1:0] image_length;
    logic [1:0]        status;

    modport source (output valid, action, target_address, fill_count, byte_value,
                    image_length, status, input ready);
    modport sink   (input valid, action, target_address, fill_count, byte_value,
                    image_length, status, output ready);
endinterface

`default_nettype wire

@@ sv/ips_patch_stream_parser.sv @@
// ips patch stream parser top level
//
//   channel   dir  beat                          width
//   i_patch   in   patch_byte, last_byte         8 + 1
//   o_cmd     out  action, target_address,       2 + 25 + 16 + 8 + 25 + 2
//                  fill_count, byte_value,
//                  image_length, status
//   i_cfg_*   in   source_length write            25
//
// one byte per cycle sustained while the command channel is not stalled; an input beat reaches its
// command beat through the input register, then decode and state update into the result register
// every input beat gives exactly one command beat, action none when nothing is written
// a stalled command beat holds the result register; the input register keeps taking
// beats only while the result register can drain
// synchronous active-low reset; a beat flagged last re-arms the parser
`default_nettype none

module ips_patch_stream_parser import ipsp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ipsp_byte_if.sink              i_patch,
    ipsp_cmd_if.source             o_cmd,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [ADDR_W-1:0] i_cfg_wr_data
);

`include "ips_patch_stream_parser_assert.svh"

    logic       w_beat_vld;
    t_beat      w_beat;
    logic       w_out_free;
    logic       w_adv;
    t_result    w_result;
    t_core_stat w_stat;

    assign w_adv = w_beat_vld && w_out_free;

    ipsp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_patch (i_patch),
        .i_take  (w_adv),
        .o_vld   (w_beat_vld),
        .o_beat  (w_beat)
    );

    ipsp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (w_adv),
        .i_beat        (w_beat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (w_result),
        .o_stat        (w_stat)
    );

    ipsp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_adv),
        .i_result (w_result),
        .o_free   (w_out_free),
        .o_cmd    (o_cmd)
    );

    // a decided patch parks in the done phase until re-armed
    `IPSP_ASSERT_NOW(a_outcome_done, w_stat.outcome != ST_RUNNING,
        w_stat.phase == PH_DONE, "outcome set outside done phase")

    // the last beat returns the parser to a fresh header
    `IPSP_ASSERT_NEXT(a_last_rearms, w_adv && w_beat.last_byte,
        w_stat.phase == PH_HEADER && w_stat.bytes_seen == '0
        && w_stat.outcome == ST_RUNNING, "last beat did not re-arm")

    // writes and fills never land beyond the reported image length
    `IPSP_ASSERT_NOW(a_len_covers, o_cmd.valid && o_cmd.action != ACT_NONE,
        o_cmd.image_length >= o_cmd.target_address, "command beyond image length")

endmodule

`default_nettype wire

@@ sv/ipsp_in_stage.sv @@
// input register for patch bytes
`default_nettype none

module ipsp_in_stage import ipsp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ipsp_byte_if.sink   i_patch,
    input  wire logic   i_take,
    output logic        o_vld,
    output t_beat       o_beat
);

    logic  r_vld;
    t_beat r_beat;

    assign i_patch.ready = !r_vld || i_take;
    assign o_vld         = r_vld;
    assign o_beat        = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_patch.ready) begin
            r_vld <= i_patch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_patch.valid && i_patch.ready) begin
            r_beat.patch_byte <= i_patch.patch_byte;
            r_beat.last_byte  <= i_patch.last_byte;
        end
    end

endmodule

`default_nettype wire

@@ sv/ipsp_core.sv @@
// parser state and per-byte decode of the ips record stream
`default_nettype none

module ipsp_core import ipsp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire t_beat             i_beat,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [ADDR_W-1:0] i_cfg_wr_data,
    output t_result                o_result,
    output t_core_stat             o_stat
);

    t_phase            r_phase,    n_phase;
    logic [IDX_W-1:0]  r_idx,      n_idx;
    logic [SEEN_W-1:0] r_seen,     n_seen;
    logic [OFF_W-1:0]  r_off,      n_off;
    logic [CNT_W-1:0]  r_cnt,      n_cnt;
    logic [ADDR_W-1:0] r_next,     n_next;
    logic [ADDR_W-1:0] r_len,      n_len;
    t_status           r_outcome,  n_outcome;
    logic [ADDR_W-1:0] r_src_len;

    logic [BYTE_W-1:0] w_b;
    logic [OFF_W-1:0]  w_off_sh;
    logic [CNT_W-1:0]  w_cnt_sh;
    logic [CNT_W-1:0]  w_grow_cnt;
    logic [ADDR_W-1:0] w_end;
    logic [ADDR_W-1:0] w_grown;
    logic [IDX_W-1:0]  w_idx_inc;
    logic [CNT_W-1:0]  w_cnt_dec;
    t_status           w_status;

    assign w_b        = i_beat.patch_byte;
    assign w_off_sh   = {r_off[OFF_W-BYTE_W-1:0], w_b};
    assign w_cnt_sh   = {r_cnt[CNT_W-BYTE_W-1:0], w_b};
    assign w_idx_inc  = r_idx + IDX_W'(1);
    assign w_cnt_dec  = r_cnt - CNT_W'(1);
    // length phase grows with the freshly completed count, run phase with the stored one
    assign w_grow_cnt = (r_phase == PH_RUN) ? r_cnt : w_cnt_sh;
    assign w_end      = ADDR_W'(r_off) + ADDR_W'(w_grow_cnt);
    assign w_grown    = (w_end > r_len) ? w_end : r_len;

    always_comb begin
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_off     = r_off;
        n_cnt     = r_cnt;
        n_next    = r_next;
        n_len     = r_len;
        n_outcome = r_outcome;
        n_seen    = (r_seen < MIN_PATCH) ? r_seen + SEEN_W'(1) : r_seen;

        o_result.action         = ACT_NONE;
        o_result.target_address = '0;
        o_result.fill_count     = '0;
        o_result.byte_value     = '0;

        unique case (r_phase)
            PH_HEADER: begin
                if (r_idx >= HDR_LEN || w_b != hdr_byte(r_idx)) begin
                    n_outcome = ST_BAD;
                    n_phase   = PH_DONE;
                end else if (w_idx_inc == HDR_LEN) begin
                    n_phase = PH_OFFSET;
                    n_idx   = '0;
                    n_off   = '0;
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            PH_OFFSET: begin
                n_off = w_off_sh;
                if (r_idx >= IDX_W'(2)) begin
                    n_idx = '0;
                    if (w_off_sh == EOF_TAG) begin
                        n_outcome = ST_OK;
                        n_phase   = PH_DONE;
                    end else begin
                        n_phase = PH_LENGTH;
                        n_cnt   = '0;
                    end
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            PH_LENGTH: begin
                n_cnt = w_cnt_sh;
                if (r_idx >= IDX_W'(1)) begin
                    n_idx = '0;
                    if (w_cnt_sh == '0) begin
                        n_phase = PH_RUN;
                    end else begin
                        n_len   = w_grown;
                        n_next  = ADDR_W'(r_off);
                        n_phase = PH_DATA;
                    end
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            PH_RUN: begin
                if (r_idx < IDX_W'(2)) begin
                    n_cnt = w_cnt_sh;
                    n_idx = w_idx_inc;
                end else begin
                    n_len                   = w_grown;
                    o_result.action         = ACT_FILL;
                    o_result.target_address = ADDR_W'(r_off);
                    o_result.fill_count     = r_cnt;
                    o_result.byte_value     = w_b;
                    n_phase                 = PH_OFFSET;
                    n_idx                   = '0;
                    n_off                   = '0;
                end
            end
            PH_DATA: begin
                o_result.action         = ACT_WRITE;
                o_result.target_address = r_next;
                o_result.byte_value     = w_b;
                n_next                  = r_next + ADDR_W'(1);
                n_cnt                   = w_cnt_dec;
                if (w_cnt_dec == '0) begin
                    n_phase = PH_OFFSET;
                    n_idx   = '0;
                    n_off   = '0;
                end
            end
            default: begin
            end
        endcase

        // a patch that ends while still running is judged by where it stopped
        w_status = n_outcome;
        if (i_beat.last_byte && n_outcome == ST_RUNNING) begin
            w_status = (n_seen >= MIN_PATCH && n_phase == PH_OFFSET) ? ST_OK : ST_BAD;
        end
        o_result.status       = w_status;
        o_result.image_length = n_len;

        // last beat re-arms for the next patch
        if (i_beat.last_byte) begin
            n_phase   = PH_HEADER;
            n_idx     = '0;
            n_seen    = '0;
            n_off     = '0;
            n_cnt     = '0;
            n_next    = '0;
            n_len     = r_src_len;
            n_outcome = ST_RUNNING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_idx     <= '0;
            r_seen    <= '0;
            r_off     <= '0;
            r_cnt     <= '0;
            r_next    <= '0;
            r_len     <= '0;
            r_outcome <= ST_RUNNING;
            r_src_len <= '0;
        end else begin
            if (i_adv) begin
                r_phase   <= n_phase;
                r_idx     <= n_idx;
                r_seen    <= n_seen;
                r_off     <= n_off;
                r_cnt     <= n_cnt;
                r_next    <= n_next;
                r_outcome <= n_outcome;
            end
            if (i_cfg_wr_en && r_seen == '0) begin
                r_len <= i_cfg_wr_data;
            end else if (i_adv) begin
                r_len <= n_len;
            end
            if (i_cfg_wr_en) begin
                r_src_len <= i_cfg_wr_data;
            end
        end
    end

    assign o_stat.phase      = r_phase;
    assign o_stat.outcome    = r_outcome;
    assign o_stat.bytes_seen = r_seen;

endmodule

`default_nettype wire

@@ sv/ipsp_out_stage.sv @@
// result register driving the command channel
`default_nettype none

module ipsp_out_stage import ipsp_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_free,
    ipsp_cmd_if.source   o_cmd
);

    logic    r_vld;
    t_result r_res;

    assign o_free = !r_vld || o_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_cmd.valid          = r_vld;
    assign o_cmd.action         = r_res.action;
    assign o_cmd.target_address = r_res.target_address;
    assign o_cmd.fill_count     = r_res.fill_count;
    assign o_cmd.byte_value     = r_res.byte_value;
    assign o_cmd.image_length   = r_res.image_length;
    assign o_cmd.status         = r_res.status;

endmodule

`default_nettype wire
